[rtl/core/epf_pkg.sv]
// Shared types, register codes and range table builder for the edge-preserving pixel filter.
package epf_pkg;

    localparam int CFG_DIM_W = 12;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int RANGE_FRAC_BITS_DEF = 16;
    localparam int NUM_TAPS = 9;
    localparam int CENTER_TAP = 4;

    localparam logic [11:0] RST_FRAME_WIDTH = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [1:0] RST_NOISE_LEVEL = 2'd1;
    localparam logic [7:0] RST_WEIGHT_CORNER = 8'd13;
    localparam logic [7:0] RST_WEIGHT_EDGE = 8'd26;
    localparam logic [7:0] RST_WEIGHT_CENTER = 8'd102;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_NOISE_LEVEL = 3'd2;
    localparam logic [2:0] REG_WEIGHT_CORNER = 3'd3;
    localparam logic [2:0] REG_WEIGHT_EDGE = 3'd4;
    localparam logic [2:0] REG_WEIGHT_CENTER = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // RGBA, red in bits 7:0 up to alpha in bits 31:24
    typedef logic [31:0] t_pixel;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_DRN,
        ST_FILT,
        ST_PUSH
    } t_state;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_ISSUE,
        FS_DRAIN,
        FS_DIV
    } t_fstate;

    localparam longint EXP_M1_Q30 = 64'd395007542;
    localparam int TAYLOR_TERMS = 14;
    localparam int MAX_IPART = 34;

    // strength * 65025 in hundredths for noise levels 0..3
    function automatic longint den_of(input int n);
        case (n)
            0: return 64'd195075;
            1: return 64'd325125;
            2: return 64'd520200;
            default: return 64'd650250;
        endcase
    endfunction

    function automatic longint den_div(input longint x, input int n);
        case (n)
            0: return x / 64'd195075;
            1: return x / 64'd325125;
            2: return x / 64'd520200;
            default: return x / 64'd650250;
        endcase
    endfunction

    function automatic longint term_div(input longint x, input int t);
        case (t)
            2: return x / 64'd2;
            3: return x / 64'd3;
            4: return x / 64'd4;
            5: return x / 64'd5;
            6: return x / 64'd6;
            7: return x / 64'd7;
            8: return x / 64'd8;
            9: return x / 64'd9;
            10: return x / 64'd10;
            11: return x / 64'd11;
            12: return x / 64'd12;
            13: return x / 64'd13;
            14: return x / 64'd14;
            default: return x;
        endcase
    endfunction

    // exp(-(d/255)^2 / strength) rounded to frac fraction bits, saturated
    function automatic logic [31:0] range_entry(input int n, input int d, input int frac);
        longint num;
        longint ipart;
        longint fq;
        longint term;
        longint acc;
        longint r;
        longint top;
        num = 64'd100 * longint'(d) * longint'(d);
        ipart = den_div(num, n);
        fq = den_div((num - ipart * den_of(n)) << 30, n);
        term = 64'd1 << 30;
        acc = 64'd1 << 30;
        for (int t = 1; t <= TAYLOR_TERMS; t++) begin
            term = term_div((term * fq) >>> 30, t);
            acc = (t % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) begin
            acc = 0;
        end
        for (int k = 0; k < MAX_IPART; k++) begin
            if (longint'(k) < ipart && acc != 0) begin
                acc = (acc * EXP_M1_Q30) >>> 30;
            end
        end
        r = (acc + (64'd1 << (29 - frac))) >>> (30 - frac);
        top = (64'd1 << frac) - 1;
        return (r > top) ? top[31:0] : r[31:0];
    endfunction

endpackage

[rtl/core/edge_preserving_3x3_pixel_filter_core.sv]
// Top level: pixel stream control, line stores, 3x3 window, config port and result register.
//
// RGBA pixels enter in raster order; each interior pixel leaves as a 3x3 bilateral
// average of R, G and B (alpha unchanged), border pixels unchanged, one result per
// pixel lagging by frame_width+1 transfers, and drain transfers (op=1) after the last
// pixel flush the remaining results, the last one flagged frame_end. The block takes
// one transfer at a time, with the input stalled until it is done: an interior pixel
// waits on the shared tap multiply-accumulate (nine taps per channel through a
// three-stage pipeline, then drained) and the 8-step restoring divider run once per
// channel; border pixels and drains that give a result skip the filter, pixels
// without a result and ignored transfers skip the output register too, and every
// result may wait on the output register. Writing frame_width or frame_height restarts
// the frame. Line stores come up with no defined contents and need no clearing.
module edge_preserving_3x3_pixel_filter_core
    import epf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int W_W = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int EMIT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int EXT_W = (W_W > CFG_DIM_W) ? W_W : CFG_DIM_W;
    localparam int EXT_H = (RW > CFG_DIM_W) ? RW : CFG_DIM_W;

    // configuration
    logic [11:0] r_cfg_w, r_cfg_h;
    logic [1:0]  r_noise;
    logic [7:0]  r_wt_corner, r_wt_edge, r_wt_center;
    logic        cfg_wr, restart;
    logic [EXT_W-1:0] w_ext;
    logic [EXT_H-1:0] h_ext;
    logic [W_W-1:0] eff_w;
    logic [RW-1:0]  eff_h;

    // stream control
    t_state            r_state, n_state;
    logic [AW-1:0]     r_col, n_col, r_c, n_c;
    logic [RW-1:0]     r_row, n_row;
    logic [EMIT_W-1:0] r_emit, n_emit, r_total;
    logic [EMIT_W-1:0] last_row;
    t_pixel            r_win [NUM_TAPS];
    t_pixel            n_win [NUM_TAPS];
    t_in_item          r_item, n_item;
    logic              r_drain_mid, n_drain_mid;
    t_pixel            r_res, n_res;
    logic              r_fe, n_fe;
    logic              r_filt_start, n_filt_start;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    // line stores and filter
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_pixel        up_q, mid_q;
    logic          filt_done;
    logic [23:0]   filt_rgb;

    // per-pixel decode
    logic          accept, c1, emit, border;
    logic [RW-1:0] qy;
    logic [W_W-1:0] qx, c_next;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign restart = cfg_wr &&
        (paddr[4:2] == REG_FRAME_WIDTH || paddr[4:2] == REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_FRAME_WIDTH;
            r_cfg_h <= RST_FRAME_HEIGHT;
            r_noise <= RST_NOISE_LEVEL;
            r_wt_corner <= RST_WEIGHT_CORNER;
            r_wt_edge <= RST_WEIGHT_EDGE;
            r_wt_center <= RST_WEIGHT_CENTER;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_FRAME_WIDTH: r_cfg_w <= pwdata[11:0];
                REG_FRAME_HEIGHT: r_cfg_h <= pwdata[11:0];
                REG_NOISE_LEVEL: r_noise <= pwdata[1:0];
                REG_WEIGHT_CORNER: r_wt_corner <= pwdata[7:0];
                REG_WEIGHT_EDGE: r_wt_edge <= pwdata[7:0];
                REG_WEIGHT_CENTER: r_wt_center <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FRAME_WIDTH: prdata = {20'd0, r_cfg_w};
            REG_FRAME_HEIGHT: prdata = {20'd0, r_cfg_h};
            REG_NOISE_LEVEL: prdata = {30'd0, r_noise};
            REG_WEIGHT_CORNER: prdata = {24'd0, r_wt_corner};
            REG_WEIGHT_EDGE: prdata = {24'd0, r_wt_edge};
            REG_WEIGHT_CENTER: prdata = {24'd0, r_wt_center};
            default: prdata = '0;
        endcase
    end

    // frame size clamped to 1..MAX
    assign w_ext = EXT_W'(r_cfg_w);
    assign h_ext = EXT_H'(r_cfg_h);
    always_comb begin
        if (w_ext == '0) begin
            eff_w = W_W'(1);
        end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(w_ext);
        end
        if (h_ext == '0) begin
            eff_h = RW'(1);
        end else if (h_ext > EXT_H'(MAX_HEIGHT)) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(h_ext);
        end
    end

    // pixel count of the frame, registered from the clamped frame size
    always_ff @(posedge i_clk) begin
        r_total <= EMIT_W'(EMIT_W'(eff_w) * EMIT_W'(eff_h));
    end
    assign last_row = r_total - EMIT_W'(eff_w);

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    epf_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mid_q),
        .o_rdata (up_q)
    );

    epf_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_middle (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata ({r_item.alpha, r_item.blue, r_item.green, r_item.red}),
        .o_rdata (mid_q)
    );

    epf_filter_unit #(.RANGE_FRAC_BITS(RANGE_FRAC_BITS)) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_filt_start),
        .i_win       (r_win),
        .i_noise     (r_noise),
        .i_wt_corner (r_wt_corner),
        .i_wt_edge   (r_wt_edge),
        .i_wt_center (r_wt_center),
        .o_done      (filt_done),
        .o_rgb       (filt_rgb)
    );

    // position of the pixel whose result is due, relative to the arriving one
    assign c1 = (r_c != '0);
    assign emit = (r_row >= RW'(2)) || (r_row == RW'(1) && c1);
    assign qy = c1 ? r_row - RW'(1) : r_row - RW'(2);
    assign qx = c1 ? W_W'(r_c) - W_W'(1) : eff_w - W_W'(1);
    assign border = (qy == '0) || (qy + RW'(1) == eff_h) ||
                    (qx == '0) || (qx + W_W'(1) == eff_w);
    assign c_next = W_W'(r_c) + W_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_emit <= '0;
            r_filt_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_filt_start <= n_filt_start;
            r_out_valid <= n_out_valid;
            if (restart) begin
                r_col <= '0;
                r_row <= '0;
                r_emit <= '0;
                for (int i = 0; i < NUM_TAPS; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                r_emit <= n_emit;
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_c <= n_c;
        r_drain_mid <= n_drain_mid;
        r_res <= n_res;
        r_fe <= n_fe;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_col = r_col;
        n_row = r_row;
        n_emit = r_emit;
        n_win = r_win;
        n_item = r_item;
        n_c = r_c;
        n_drain_mid = r_drain_mid;
        n_res = r_res;
        n_fe = r_fe;
        n_filt_start = 1'b0;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we = 1'b0;
        mem_addr = r_col;
        case (r_state)
            ST_IDLE: begin
                if (i_in_data.op == OP_DRAIN) begin
                    n_drain_mid = (r_emit >= last_row);
                    mem_addr = n_drain_mid ? AW'(r_emit - last_row) : AW'(eff_w - W_W'(1));
                end
                if (accept) begin
                    n_item = i_in_data;
                    n_c = r_col;
                    if (i_in_data.op == OP_PIXEL) begin
                        // pixels after the last row are dropped until the flush ends
                        if (r_row < eff_h) begin
                            n_state = ST_PIX;
                        end
                    end else if (r_row >= eff_h && r_emit < r_total) begin
                        n_state = ST_DRN;
                    end
                end
            end
            ST_PIX: begin
                mem_we = 1'b1;
                mem_addr = r_c;
                for (int r = 0; r < 3; r++) begin
                    n_win[r * 3] = r_win[r * 3 + 1];
                    n_win[r * 3 + 1] = r_win[r * 3 + 2];
                end
                n_win[2] = up_q;
                n_win[5] = mid_q;
                n_win[8] = {r_item.alpha, r_item.blue, r_item.green, r_item.red};
                if (c_next >= eff_w) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = AW'(c_next);
                end
                n_fe = 1'b0;
                if (!emit) begin
                    n_state = ST_IDLE;
                end else begin
                    n_emit = r_emit + EMIT_W'(1);
                    if (border) begin
                        // new center is the old right-middle tap
                        n_res = r_win[5];
                        n_state = ST_PUSH;
                    end else begin
                        n_filt_start = 1'b1;
                        n_state = ST_FILT;
                    end
                end
            end
            ST_DRN: begin
                n_res = r_drain_mid ? mid_q : up_q;
                n_emit = r_emit + EMIT_W'(1);
                n_fe = (n_emit == r_total);
                if (n_fe) begin
                    n_col = '0;
                    n_row = '0;
                    n_emit = '0;
                end
                n_state = ST_PUSH;
            end
            ST_FILT: begin
                if (filt_done) begin
                    n_res = {r_win[CENTER_TAP][31:24], filt_rgb};
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_red = r_res[7:0];
                    n_out.out_green = r_res[15:8];
                    n_out.out_blue = r_res[23:16];
                    n_out.out_alpha = r_res[31:24];
                    n_out.frame_end = r_fe;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W_W'(r_col) < eff_w) else $error("column count beyond frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= eff_h) else $error("row count beyond frame height");

    a_filt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        filt_done |-> r_state == ST_FILT) else $error("filter finished while not in use");

    a_push_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && !r_out_valid) |=> o_out_valid)
        else $error("result not loaded into free output register");

endmodule

[rtl/core/epf_line_store.sv]
// Single-port line store with registered read data.
module epf_line_store
    import epf_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  t_pixel        i_wdata,
    output t_pixel        o_rdata
);

    t_pixel r_mem [DEPTH];
    t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/epf_filter_unit.sv]
// Shared tap multiply-accumulate and restoring divider for the three color channels.
module epf_filter_unit
    import epf_pkg::*;
#(
    parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_pixel      i_win [NUM_TAPS],
    input  logic [1:0]  i_noise,
    input  logic [7:0]  i_wt_corner,
    input  logic [7:0]  i_wt_edge,
    input  logic [7:0]  i_wt_center,
    output logic        o_done,
    output logic [23:0] o_rgb
);

    localparam int F = RANGE_FRAC_BITS;
    localparam int KW_W = 8 + F;
    localparam int PROD_W = 16 + F;
    localparam int SUM_W = PROD_W + 4;
    localparam int WSUM_W = KW_W + 4;
    localparam int ROM_DEPTH = 1024;

    typedef logic [F-1:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = F'(range_entry(i / 256, i % 256, F));
        end
        return rom;
    endfunction

    localparam t_rom RANGE_ROM = build_rom();

    t_fstate             r_state, n_state;
    logic [1:0]          r_ch, n_ch;
    logic [3:0]          r_tap, n_tap;
    logic [2:0]          r_v;
    logic [F-1:0]        r_s1_rom;
    logic [7:0]          r_s1_sw, r_s1_nv, r_s2_nv;
    logic [KW_W-1:0]     r_s2_kw, r_s3_kw;
    logic [PROD_W-1:0]   r_s3_prod;
    logic [SUM_W-1:0]    r_sum, r_rem, n_rem;
    logic [WSUM_W-1:0]   r_wsum;
    logic [7:0]          r_quo, n_quo;
    logic [2:0]          r_bit, n_bit;
    logic [23:0]         r_res, n_res;
    logic                r_done, n_done;
    logic                issue, clr;
    logic [7:0]          nv, cv, diff, sw;
    logic [SUM_W-1:0]    trial;
    logic                ge;

    assign issue = (r_state == FS_ISSUE);
    assign nv = i_win[r_tap][{r_ch, 3'b000} +: 8];
    assign cv = i_win[CENTER_TAP][{r_ch, 3'b000} +: 8];
    assign diff = (cv > nv) ? cv - nv : nv - cv;
    assign trial = SUM_W'(r_wsum) << r_bit;
    assign ge = (r_rem >= trial);

    always_comb begin
        if (r_tap == 4'(CENTER_TAP)) begin
            sw = i_wt_center;
        end else if (r_tap[0]) begin
            sw = i_wt_edge;
        end else begin
            sw = i_wt_corner;
        end
    end

    // tap pipeline: ROM read, spatial x range, value x weight, accumulate
    always_ff @(posedge i_clk) begin
        r_s1_rom <= RANGE_ROM[{i_noise, diff}];
        r_s1_sw <= sw;
        r_s1_nv <= nv;
        r_s2_kw <= KW_W'(r_s1_sw) * KW_W'(r_s1_rom);
        r_s2_nv <= r_s1_nv;
        r_s3_prod <= PROD_W'(r_s2_nv) * PROD_W'(r_s2_kw);
        r_s3_kw <= r_s2_kw;
        if (clr) begin
            r_sum <= '0;
            r_wsum <= '0;
        end else if (r_v[2]) begin
            r_sum <= r_sum + SUM_W'(r_s3_prod);
            r_wsum <= r_wsum + WSUM_W'(r_s3_kw);
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_ch <= '0;
            r_tap <= '0;
            r_v <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch <= n_ch;
            r_tap <= n_tap;
            r_v <= {r_v[1:0], issue};
            r_done <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch = r_ch;
        n_tap = r_tap;
        n_rem = r_rem;
        n_quo = r_quo;
        n_bit = r_bit;
        n_res = r_res;
        n_done = 1'b0;
        clr = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (i_start) begin
                    n_state = FS_ISSUE;
                    n_ch = '0;
                    n_tap = '0;
                    clr = 1'b1;
                end
            end
            FS_ISSUE: begin
                if (r_tap == 4'(NUM_TAPS - 1)) begin
                    n_state = FS_DRAIN;
                end else begin
                    n_tap = r_tap + 4'd1;
                end
            end
            FS_DRAIN: begin
                if (r_v == 3'b000) begin
                    n_state = FS_DIV;
                    n_rem = r_sum;
                    n_quo = '0;
                    n_bit = 3'd7;
                end
            end
            FS_DIV: begin
                if (ge) begin
                    n_rem = r_rem - trial;
                    n_quo[r_bit] = 1'b1;
                end
                n_bit = r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    // no weight at all: keep the center value
                    n_res[{r_ch, 3'b000} +: 8] = (r_wsum == '0) ? cv : n_quo;
                    if (r_ch == 2'd2) begin
                        n_state = FS_IDLE;
                        n_done = 1'b1;
                    end else begin
                        n_state = FS_ISSUE;
                        n_ch = r_ch + 2'd1;
                        n_tap = '0;
                        clr = 1'b1;
                    end
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_rgb = r_res;

endmodule

[tb/edge_preserving_3x3_pixel_filter_core_test.sv]
// Testbench for the edge-preserving 3x3 pixel filter: random and directed frames, scoreboard check.
`timescale 1ns / 100ps

module edge_preserving_3x3_pixel_filter_core_test;
    import epf_pkg::*;

    // Holds a bit-true copy of the filter state and the queue of pixels it must emit.
    class filter_scoreboard;
        bit [31:0] upper_row[2048];
        bit [31:0] middle_row[2048];
        bit [31:0] win[9];
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned sent_pos;
        int unsigned fw_reg;
        int unsigned fh_reg;
        int unsigned noise_reg;
        int unsigned wt_corner;
        int unsigned wt_edge;
        int unsigned wt_center;
        int unsigned gauss_rom[4][256];
        t_out_item pending_px[$];
        int errors;
        int accepted;

        function new();
            longint unsigned strength[4];
            longint unsigned den;
            longint unsigned num;
            longint unsigned ipart;
            longint fq;
            longint term;
            longint acc;
            longint unsigned r;
            strength = '{3, 5, 8, 10};
            for (int n = 0; n < 4; n++) begin
                den = 65025 * strength[n];
                for (int d = 0; d < 256; d++) begin
                    num = 100 * longint'(d) * longint'(d);
                    ipart = num / den;
                    fq = longint'(((num % den) << 30) / den);
                    term = 64'sd1 << 30;
                    acc = 64'sd1 << 30;
                    for (int t = 1; t <= 14; t++) begin
                        term = ((term * fq) >>> 30) / t;
                        acc = (t % 2 == 1) ? acc - term : acc + term;
                    end
                    if (acc < 0) begin
                        acc = 0;
                    end
                    for (longint unsigned k = 0; k < ipart && acc != 0; k++) begin
                        acc = (acc * 64'sd395007542) >>> 30;
                    end
                    r = (longint'(acc) + (64'd1 << 13)) >> 14;
                    gauss_rom[n][d] = (r > 65535) ? 65535 : int'(r);
                end
            end
            fw_reg = RST_FRAME_WIDTH;
            fh_reg = RST_FRAME_HEIGHT;
            noise_reg = RST_NOISE_LEVEL;
            wt_corner = RST_WEIGHT_CORNER;
            wt_edge = RST_WEIGHT_EDGE;
            wt_center = RST_WEIGHT_CENTER;
            restart();
        endfunction

        function void restart();
            col_pos = 0;
            row_pos = 0;
            sent_pos = 0;
            for (int k = 0; k < 9; k++) begin
                win[k] = '0;
            end
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) begin
                return 1;
            end
            return (v > 2048) ? 2048 : v;
        endfunction

        function int unsigned eff_width();
            return clamp_dim(fw_reg);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(fh_reg);
        endfunction

        function void write_reg(logic [2:0] idx, int unsigned val);
            case (idx)
                REG_FRAME_WIDTH: begin
                    fw_reg = val & 12'hfff;
                    restart();
                end
                REG_FRAME_HEIGHT: begin
                    fh_reg = val & 12'hfff;
                    restart();
                end
                REG_NOISE_LEVEL: noise_reg = val & 3;
                REG_WEIGHT_CORNER: wt_corner = val & 8'hff;
                REG_WEIGHT_EDGE: wt_edge = val & 8'hff;
                REG_WEIGHT_CENTER: wt_center = val & 8'hff;
                default: ;
            endcase
        endfunction

        function bit [31:0] smooth_window();
            bit [31:0] res;
            longint unsigned acc_sum;
            longint unsigned acc_wt;
            longint unsigned kw;
            int unsigned cv;
            int unsigned nv;
            int unsigned diff;
            int unsigned sw;
            res = win[CENTER_TAP] & 32'hff00_0000;
            for (int ch = 0; ch < 3; ch++) begin
                cv = (win[CENTER_TAP] >> (8 * ch)) & 8'hff;
                acc_sum = 0;
                acc_wt = 0;
                for (int k = 0; k < 9; k++) begin
                    nv = (win[k] >> (8 * ch)) & 8'hff;
                    diff = (cv > nv) ? cv - nv : nv - cv;
                    sw = (k == CENTER_TAP) ? wt_center : ((k % 2 == 1) ? wt_edge : wt_corner);
                    kw = longint'(sw) * gauss_rom[noise_reg][diff];
                    acc_sum += longint'(nv) * kw;
                    acc_wt += kw;
                end
                nv = (acc_wt != 0) ? int'(acc_sum / acc_wt) : cv;
                res |= (nv & 8'hff) << (8 * ch);
            end
            return res;
        endfunction

        function void push_px(bit [31:0] px, bit fe);
            t_out_item o;
            o.out_red = px[7:0];
            o.out_green = px[15:8];
            o.out_blue = px[23:16];
            o.out_alpha = px[31:24];
            o.frame_end = fe;
            pending_px.push_back(o);
        endfunction

        // Accepted input transfer: advance the state, queue what it produces.
        function void note_input(t_in_item it);
            int unsigned w;
            int unsigned h;
            int unsigned total;
            int unsigned c;
            int unsigned qy;
            int unsigned qx;
            int unsigned last_row;
            bit [31:0] px;
            bit [31:0] top;
            bit [31:0] mid;
            bit emit;
            bit fe;
            w = eff_width();
            h = eff_height();
            total = w * h;
            accepted++;
            if (it.op == OP_PIXEL) begin
                if (row_pos >= h) begin
                    return;
                end
                px = {it.alpha, it.blue, it.green, it.red};
                c = (col_pos >= w) ? 0 : col_pos;
                top = upper_row[c];
                mid = middle_row[c];
                upper_row[c] = mid;
                middle_row[c] = px;
                for (int r = 0; r < 3; r++) begin
                    win[r * 3] = win[r * 3 + 1];
                    win[r * 3 + 1] = win[r * 3 + 2];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = px;
                emit = row_pos >= 2 || (row_pos == 1 && c >= 1);
                qy = (c >= 1) ? row_pos - 1 : row_pos - 2;
                qx = (c >= 1) ? c - 1 : w - 1;
                if (c + 1 >= w) begin
                    col_pos = 0;
                    row_pos++;
                end else begin
                    col_pos = c + 1;
                end
                if (!emit) begin
                    return;
                end
                if (qy == 0 || qy + 1 == h || qx == 0 || qx + 1 == w) begin
                    push_px(win[CENTER_TAP], 1'b0);
                end else begin
                    push_px(smooth_window(), 1'b0);
                end
                sent_pos++;
                return;
            end
            // drain: only after the last pixel, until the frame is flushed
            if (row_pos < h || sent_pos >= total) begin
                return;
            end
            last_row = total - w;
            px = (sent_pos >= last_row) ? middle_row[sent_pos - last_row] : upper_row[w - 1];
            sent_pos++;
            fe = (sent_pos == total);
            push_px(px, fe);
            if (fe) begin
                col_pos = 0;
                row_pos = 0;
                sent_pos = 0;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_output(t_out_item got);
            t_out_item want;
            if (pending_px.size() == 0) begin
                report("output transfer with nothing expected");
                return;
            end
            want = pending_px.pop_front();
            if (got.out_red !== want.out_red)
                report($sformatf("red %0h, want %0h", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report($sformatf("green %0h, want %0h", got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report($sformatf("blue %0h, want %0h", got.out_blue, want.out_blue));
            if (got.out_alpha !== want.out_alpha)
                report($sformatf("alpha %0h, want %0h", got.out_alpha, want.out_alpha));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    filter_scoreboard sb;
    bit idle_on;          // random idling on both sides
    bit hold_req;         // ask the output side for one long hold-off
    int hold_left;
    int stall_burst;

    edge_preserving_3x3_pixel_filter_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Output side: check every transfer, stall in random bursts or one long hold.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_output(o_out_data);
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_burst = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one input transfer and wait until it is taken; valid stays high afterward.
    task automatic send_item(logic op, logic [31:0] px);
        t_in_item it;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        it.op = op;
        it.red = px[7:0];
        it.green = px[15:8];
        it.blue = px[23:16];
        it.alpha = px[31:24];
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    // Drop valid, wait for every expected pixel, then let any no-result work finish.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_filter(int unsigned nl, int unsigned wc, int unsigned we,
                              int unsigned wm);
        wait_quiet();
        reg_write(REG_NOISE_LEVEL, nl);
        reg_write(REG_WEIGHT_CORNER, wc);
        reg_write(REG_WEIGHT_EDGE, we);
        reg_write(REG_WEIGHT_CENTER, wm);
    endtask

    // style 0 full random, 1 smooth around a base, 2 black/white checkerboard
    function automatic logic [31:0] make_pixel(int style, int idx, logic [31:0] base);
        logic [31:0] px;
        px = $urandom;
        if (style == 1) begin
            for (int ch = 0; ch < 3; ch++) begin
                px[8 * ch +: 8] = (base[8 * ch +: 8] > 243) ? base[8 * ch +: 8] - 8'($urandom_range(0, 12))
                                                           : base[8 * ch +: 8] + 8'($urandom_range(0, 12));
            end
        end else if (style == 2) begin
            px[23:0] = (idx % 2 == 0) ? 24'hffffff : 24'h000000;
        end
        return px;
    endfunction

    // One frame: size writes, pixels, drains until frame end. Noise puts ignored
    // transfers in; a nonnegative cut stops the frame early.
    task automatic run_frame(int unsigned wr, int unsigned hr, int style, bit noise, int cut);
        int unsigned w;
        int unsigned h;
        logic [31:0] base;
        wait_quiet();
        reg_write(REG_FRAME_WIDTH, wr);
        reg_write(REG_FRAME_HEIGHT, hr);
        w = sb.eff_width();
        h = sb.eff_height();
        base = $urandom;
        for (int i = 0; i < w * h; i++) begin
            if (i == cut) begin
                return;
            end
            if (noise && $urandom_range(0, 15) == 0) begin
                send_item(OP_DRAIN, $urandom);
            end
            send_item(OP_PIXEL, make_pixel(style, i + (i / w) * (w % 2 == 0), base));
        end
        while (sb.row_pos != 0) begin
            if (noise && $urandom_range(0, 9) == 0) begin
                send_item(OP_PIXEL, $urandom);
            end
            send_item(OP_DRAIN, $urandom);
        end
    endtask

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned wr;
        int unsigned hr;
        sb = new();
        idle_on = 1'b1;
        hold_req = 1'b0;
        hold_left = 0;
        stall_burst = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all noise levels on hard edges, extreme and zero weights
        for (int n = 0; n < 4; n++) begin
            set_filter(n, 13, 26, 102);
            run_frame(4, 3, 2, 1'b0, -1);
        end
        set_filter(3, 255, 255, 255);
        run_frame(4, 4, 0, 1'b0, -1);
        // zero weight sum: every channel keeps its center value
        set_filter(0, 0, 0, 0);
        run_frame(3, 3, 0, 1'b0, -1);
        set_filter(2, 0, 0, 1);
        run_frame(3, 4, 2, 1'b0, -1);
        set_filter(1, 13, 26, 102);
        // size extremes: zero clamps to one, all ones to the maximum
        run_frame(0, 3, 0, 1'b0, -1);
        run_frame(4, 0, 0, 1'b1, -1);
        run_frame(4095, 1, 0, 1'b0, 200);
        run_frame(1, 4095, 1, 1'b0, 200);
        // restart in the middle of a frame
        run_frame(5, 4, 0, 1'b1, 9);

        // long output hold-off while pixels keep coming
        wait_quiet();
        reg_write(REG_FRAME_WIDTH, 8);
        reg_write(REG_FRAME_HEIGHT, 6);
        for (int i = 0; i < 48; i++) begin
            if (i == 12) begin
                hold_req = 1'b1;
            end
            send_item(OP_PIXEL, $urandom);
        end
        while (sb.row_pos != 0) send_item(OP_DRAIN, $urandom);

        while (sb.accepted < 1300) begin
            if (sb.accepted > 1150) begin
                idle_on = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                wait_quiet();
                set_filter($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 255));
            end
            wr = $urandom_range(1, 9);
            hr = $urandom_range(1, 7);
            if ($urandom_range(0, 19) == 0) begin
                wr = $urandom_range(30, 64);
            end
            run_frame(wr, hr, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 7) == 0 ? int'($urandom_range(0, wr * hr)) : -1);
        end

        i_in_valid <= 1'b0;
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_px.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
